// File: src/elevator_order_scheduler_defines.svh
// ----------------------------------------------------------------------------
// elevator order scheduler assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_ORDER_SCHEDULER_DEFINES_SVH
`define ELEVATOR_ORDER_SCHEDULER_DEFINES_SVH

// property holds in every cycle once out of reset
`define EOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define EOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/eos_pkg.sv
// ----------------------------------------------------------------------------
// eos_pkg
// shared types and codes of the elevator order scheduler
// ----------------------------------------------------------------------------
package eos_pkg;

  localparam int unsigned FieldW = 4;
  localparam int unsigned FloorW = 2;

  typedef logic [FieldW-1:0] mask_t;
  typedef logic [FloorW-1:0] floor_t;

  typedef enum logic [2:0] {
    HEAD_IDLE = 3'b001,
    HEAD_UP   = 3'b010,
    HEAD_DOWN = 3'b100
  } heading_e;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_UP   = 2'd1,
    MOTOR_DOWN = 2'd2
  } motor_e;

  typedef struct packed {
    mask_t  up;
    mask_t  down;
    mask_t  cabin;
    logic   sensor_valid;
    floor_t sensor_floor;
  } tick_in_t;

  typedef struct packed {
    motor_e motor_cmd;
    logic   moving;
    logic   stop_here;
    logic   fresh_order;
    mask_t  up_lights;
    mask_t  down_lights;
    mask_t  cabin_lights;
    floor_t goal_floor;
  } result_t;

endpackage

// File: src/eos_scan.sv
// ----------------------------------------------------------------------------
// eos_scan
// ascending target scan over the floors with a pending order
// ----------------------------------------------------------------------------
module eos_scan #(
  parameter int unsigned ORDER_W = 4
) (
  input  logic [ORDER_W-1:0] any_orders_i,
  input  eos_pkg::floor_t    target_i,
  input  eos_pkg::heading_e  heading_i,
  output eos_pkg::floor_t    target_o
);
  import eos_pkg::*;

  always_comb begin
    floor_t t;
    t = target_i;
    for (int i = 0; i < int'(ORDER_W); i++) begin
      if (any_orders_i[i]) begin
        if ((floor_t'(i) > t) && (heading_i != HEAD_DOWN)) begin
          t = floor_t'(i);
        end else if ((floor_t'(i) < t) && (heading_i != HEAD_UP)) begin
          t = floor_t'(i);
        end
      end
    end
    target_o = t;
  end

endmodule

// File: src/eos_tick.sv
// ----------------------------------------------------------------------------
// eos_tick
// next state and result of one control tick
// ----------------------------------------------------------------------------
module eos_tick #(
  parameter int unsigned ORDER_W = 4
) (
  input  eos_pkg::tick_in_t  tick_i,
  input  logic [ORDER_W-1:0] up_i,
  input  logic [ORDER_W-1:0] down_i,
  input  logic [ORDER_W-1:0] cabin_i,
  input  eos_pkg::floor_t    target_i,
  input  eos_pkg::floor_t    present_i,
  input  eos_pkg::heading_e  heading_i,
  output logic [ORDER_W-1:0] up_o,
  output logic [ORDER_W-1:0] down_o,
  output logic [ORDER_W-1:0] cabin_o,
  output eos_pkg::floor_t    target_o,
  output eos_pkg::floor_t    present_o,
  output eos_pkg::heading_e  heading_o,
  output eos_pkg::result_t   result_o
);
  import eos_pkg::*;

  logic [ORDER_W-1:0] up_press, down_press, cabin_press;
  logic [ORDER_W-1:0] up_m, down_m, cabin_m;
  logic [ORDER_W-1:0] sel;
  logic               at_floor;
  logic               stop;
  floor_t             target_n;
  motor_e             motor;

  assign up_press    = ORDER_W'(tick_i.up);
  assign down_press  = ORDER_W'(tick_i.down);
  assign cabin_press = ORDER_W'(tick_i.cabin);

  assign up_m    = up_i | up_press;
  assign down_m  = down_i | down_press;
  assign cabin_m = cabin_i | cabin_press;

  // sensor beyond the shaft counts as no sensor
  assign at_floor  = tick_i.sensor_valid && (int'(tick_i.sensor_floor) < int'(ORDER_W));
  assign present_o = at_floor ? tick_i.sensor_floor : present_i;

  eos_scan #(
    .ORDER_W(ORDER_W)
  ) u_scan (
    .any_orders_i(up_m | down_m | cabin_m),
    .target_i    (target_i),
    .heading_i   (heading_i),
    .target_o    (target_n)
  );

  assign sel  = at_floor ? (ORDER_W'(1) << tick_i.sensor_floor) : '0;
  assign stop = ((cabin_m & sel) != '0)
             || (((up_m & sel) != '0) && (target_n >= tick_i.sensor_floor))
             || (((down_m & sel) != '0) && (target_n <= tick_i.sensor_floor));

  assign up_o     = stop ? (up_m & ~sel) : up_m;
  assign down_o   = stop ? (down_m & ~sel) : down_m;
  assign cabin_o  = stop ? (cabin_m & ~sel) : cabin_m;
  assign target_o = target_n;

  always_comb begin
    if (target_n > present_o) begin
      heading_o = HEAD_UP;
    end else if (target_n < present_o) begin
      heading_o = HEAD_DOWN;
    end else begin
      heading_o = HEAD_IDLE;
    end
  end

  always_comb begin
    case (heading_o)
      HEAD_UP:   motor = MOTOR_UP;
      HEAD_DOWN: motor = MOTOR_DOWN;
      default:   motor = MOTOR_STOP;
    endcase
    if (stop) begin
      motor = MOTOR_STOP;
    end
  end

  assign result_o.motor_cmd    = motor;
  assign result_o.moving       = (motor != MOTOR_STOP);
  assign result_o.stop_here    = stop;
  assign result_o.fresh_order  = ((up_press & ~up_i) | (down_press & ~down_i)
                                 | (cabin_press & ~cabin_i)) != '0;
  assign result_o.up_lights    = FieldW'(up_o);
  assign result_o.down_lights  = FieldW'(down_o);
  assign result_o.cabin_lights = FieldW'(cabin_o);
  assign result_o.goal_floor   = target_n;

endmodule

// File: src/elevator_order_scheduler.sv
// path: an accepted item is held in the input stage, then its result in the result register
// throughput: one item per cycle unless the result is stalled; the order, target and
//   heading registers load in the same cycle as the result, so ticks run back to back
// reset (rst_ni low, asynchronous): orders cleared, target and present floor 0,
//   heading idle, input and result stages empty
// ----------------------------------------------------------------------------
// elevator_order_scheduler
// collective control order scheduler: merges button presses into per-floor
// orders, picks a target floor, decides stops and drives the motor command
// ----------------------------------------------------------------------------
module elevator_order_scheduler #(
  parameter int unsigned FLOORS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tick input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  eos_pkg::mask_t      up_press_i,
  input  eos_pkg::mask_t      down_press_i,
  input  eos_pkg::mask_t      cabin_press_i,
  input  logic                sensor_valid_i,
  input  eos_pkg::floor_t     sensor_floor_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          motor_cmd_o,
  output logic                moving_o,
  output logic                stop_here_o,
  output logic                fresh_order_o,
  output eos_pkg::mask_t      up_lights_o,
  output eos_pkg::mask_t      down_lights_o,
  output eos_pkg::mask_t      cabin_lights_o,
  output eos_pkg::floor_t     goal_floor_o
);
  import eos_pkg::*;

  // buttons only reach the first FieldW floors, so wider masks would stay zero
  localparam int unsigned OrderW = (FLOORS < FieldW) ? FLOORS : FieldW;

  `include "elevator_order_scheduler_defines.svh"

  // input stage
  tick_in_t in_q;
  logic     in_valid_q, in_valid_d;
  logic     in_load;

  // scheduler state
  logic [OrderW-1:0] up_q, up_d;
  logic [OrderW-1:0] down_q, down_d;
  logic [OrderW-1:0] cabin_q, cabin_d;
  floor_t            target_q, target_d;
  floor_t            present_q, present_d;
  heading_e          heading_q, heading_d;

  // result stage
  result_t  out_q, out_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  logic     advance;

  // the result register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q.up           <= up_press_i;
      in_q.down         <= down_press_i;
      in_q.cabin        <= cabin_press_i;
      in_q.sensor_valid <= sensor_valid_i;
      in_q.sensor_floor <= sensor_floor_i;
    end
  end

  // one tick of combinational work between the input and result registers
  eos_tick #(
    .ORDER_W(OrderW)
  ) u_tick (
    .tick_i   (in_q),
    .up_i     (up_q),
    .down_i   (down_q),
    .cabin_i  (cabin_q),
    .target_i (target_q),
    .present_i(present_q),
    .heading_i(heading_q),
    .up_o     (up_d),
    .down_o   (down_d),
    .cabin_o  (cabin_d),
    .target_o (target_d),
    .present_o(present_d),
    .heading_o(heading_d),
    .result_o (out_d)
  );

  // state moves only when a tick's result goes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q      <= '0;
      down_q    <= '0;
      cabin_q   <= '0;
      target_q  <= '0;
      present_q <= '0;
      heading_q <= HEAD_IDLE;
    end else if (advance) begin
      up_q      <= up_d;
      down_q    <= down_d;
      cabin_q   <= cabin_d;
      target_q  <= target_d;
      present_q <= present_d;
      heading_q <= heading_d;
    end
  end

  // result payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_cmd_o    = out_q.motor_cmd;
  assign moving_o       = out_q.moving;
  assign stop_here_o    = out_q.stop_here;
  assign fresh_order_o  = out_q.fresh_order;
  assign up_lights_o    = out_q.up_lights;
  assign down_lights_o  = out_q.down_lights;
  assign cabin_lights_o = out_q.cabin_lights;
  assign goal_floor_o   = out_q.goal_floor;

  // a stopping cabin never drives the motor
  `EOS_ASSERT_IMP(a_stop_no_motor, out_valid_q && out_q.stop_here,
                  out_q.motor_cmd == MOTOR_STOP, "motor driven on a stop tick")
  // the shown lights are the live order state
  `EOS_ASSERT_IMP(a_lights_match, out_valid_q,
                  (out_q.up_lights == FieldW'(up_q)) && (out_q.down_lights == FieldW'(down_q))
                  && (out_q.cabin_lights == FieldW'(cabin_q)),
                  "lights differ from order state")
  // heading agrees with target and present floor
  `EOS_ASSERT_IMP(a_heading_up, heading_q == HEAD_UP, target_q > present_q,
                  "heading up without a higher target")
  `EOS_ASSERT_IMP(a_heading_down, heading_q == HEAD_DOWN, target_q < present_q,
                  "heading down without a lower target")

endmodule
